### src/jdz_pkg.sv
// jdz_pkg: shared types, constants and helpers for the joystick dead zone filter
// used by jdz_div, jdz_sqrt and joystick_dead_zone_filter; depends on nothing
`default_nettype none

package jdz_pkg;

  localparam logic [14:0] TrigDeadRst  = 15'd250;
  localparam logic [14:0] TrigFullRst  = 15'd30000;
  localparam logic [14:0] StickDeadRst = 15'd8000;
  localparam logic [15:0] StickFullRst = 16'd30000;

  localparam logic [1:0] RegTrigDead  = 2'd0;
  localparam logic [1:0] RegTrigFull  = 2'd1;
  localparam logic [1:0] RegStickDead = 2'd2;
  localparam logic [1:0] RegStickFull = 2'd3;

  localparam int DivSteps  = 16;
  localparam int SqrtSteps = 24;
  // input, square, divider, sum, root, scale, divider, multiply, round, divider, output
  localparam int PipeDepth = 1 + 1 + DivSteps + 1 + SqrtSteps + 1 + DivSteps + 1 + 1 + DivSteps + 1;

  localparam logic [15:0] FullMag = 16'h8000;

  typedef struct packed {
    logic        stick;
    logic        neg_x;
    logic        neg_y;
    logic [15:0] ax;
    logic [15:0] ay;
    logic        t_zero;
    logic        t_full;
    logic [15:0] trig_q;
    logic [31:0] sq_x;
    logic [31:0] sq_y;
    logic        s_zero;
    logic [23:0] len;
    logic        f_full;
  } side_t;

  function automatic logic [15:0] sat_out(input logic [15:0] mag, input logic neg);
    logic [15:0] r;
    if (neg) begin
      r = mag[15] ? 16'h8000 : 16'(~mag + 16'd1);
    end else begin
      r = mag[15] ? 16'h7fff : mag;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### src/joystick_dead_zone_filter.sv
// joystick_dead_zone_filter: trigger and radial stick dead zone scaling, Q1.15 results
// depends on jdz_pkg, jdz_div, jdz_sqrt
//
// channel   ports                                      handshake
// request   start, busy, kind_i, axis_x_i, axis_y_i    taken when start high, busy low
// result    done_o, out_x_o, out_y_o                   one cycle strobe, no back-pressure
// config    psel, penable, pwrite, paddr, pwdata,      apb write on access cycle
//           prdata, pready
//
// one request per cycle; results come out in the order their requests were taken
// each request passes through three 16 stage dividers and the 24 stage square root in series
// busy never rises, and the result side has no stall
// reset clears all valid bits and loads the default dead zone and full scale values
`default_nettype none

module joystick_dead_zone_filter (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        kind_i,
  input  wire logic [15:0] axis_x_i,
  input  wire logic [15:0] axis_y_i,
  output logic             done_o,
  output logic [15:0]      out_x_o,
  output logic [15:0]      out_y_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [14:0] tdz_q, tfs_q, sdz_q;
  logic [15:0] sfs_q;
  logic [29:0] dsq_q;

  assign busy   = 1'b0;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tdz_q <= jdz_pkg::TrigDeadRst;
      tfs_q <= jdz_pkg::TrigFullRst;
      sdz_q <= jdz_pkg::StickDeadRst;
      sfs_q <= jdz_pkg::StickFullRst;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        jdz_pkg::RegTrigDead:  tdz_q <= pwdata[14:0];
        jdz_pkg::RegTrigFull:  tfs_q <= pwdata[14:0];
        jdz_pkg::RegStickDead: sdz_q <= pwdata[14:0];
        jdz_pkg::RegStickFull: sfs_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      jdz_pkg::RegTrigDead:  prdata = {17'd0, tdz_q};
      jdz_pkg::RegTrigFull:  prdata = {17'd0, tfs_q};
      jdz_pkg::RegStickDead: prdata = {17'd0, sdz_q};
      jdz_pkg::RegStickFull: prdata = {16'd0, sfs_q};
      default:               prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    dsq_q <= sdz_q * sdz_q;
  end

  // input stage
  logic           v0_q;
  jdz_pkg::side_t s0_d, s0_q;

  always_comb begin
    s0_d       = '0;
    s0_d.stick = kind_i;
    s0_d.neg_x = axis_x_i[15];
    s0_d.neg_y = axis_y_i[15];
    s0_d.ax    = axis_x_i[15] ? 16'(~axis_x_i + 16'd1) : axis_x_i;
    s0_d.ay    = axis_y_i[15] ? 16'(~axis_y_i + 16'd1) : axis_y_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else begin
      v0_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    s0_q <= s0_d;
  end

  // squares and trigger setup
  logic           v1_q;
  jdz_pkg::side_t s1_d, s1_q;
  logic [16:0]    tdiff;
  logic [14:0]    td;
  logic [39:0]    tnum_d, tnum_q;
  logic [23:0]    tden_q;

  assign tdiff = {1'b0, s0_q.ax} - {2'b00, tdz_q};
  assign td    = tfs_q - tdz_q;

  always_comb begin
    s1_d        = s0_q;
    s1_d.sq_x   = s0_q.ax * s0_q.ax;
    s1_d.sq_y   = s0_q.ay * s0_q.ay;
    s1_d.t_zero = s0_q.ax <= {1'b0, tdz_q};
    s1_d.t_full = (tfs_q <= tdz_q) || (tdiff[15:0] >= {1'b0, td});
    tnum_d      = {9'd0, tdiff[15:0], 15'd0} + {26'd0, td[14:1]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= v0_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_q   <= s1_d;
    tnum_q <= tnum_d;
    tden_q <= {9'd0, td};
  end

  logic           vt;
  logic [15:0]    tq;
  jdz_pkg::side_t st;

  jdz_div u_tdiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v1_q),
    .num_i   (tnum_q),
    .den_i   (tden_q),
    .side_i  (s1_q),
    .valid_o (vt),
    .quot_o  (tq),
    .side_o  (st)
  );

  // squared length and dead zone test
  logic           vp_q;
  jdz_pkg::side_t sp_d, sp_q;
  logic [31:0]    ssum, ssum_q;

  assign ssum = st.sq_x + st.sq_y;

  always_comb begin
    sp_d        = st;
    sp_d.trig_q = tq;
    sp_d.s_zero = ssum < {2'b00, dsq_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vp_q <= 1'b0;
    end else begin
      vp_q <= vt;
    end
  end

  always_ff @(posedge clk_i) begin
    sp_q   <= sp_d;
    ssum_q <= ssum;
  end

  logic           vr;
  logic [23:0]    len;
  jdz_pkg::side_t sr;

  jdz_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (vp_q),
    .rad_i   ({ssum_q, 16'd0}),
    .side_i  (sp_q),
    .valid_o (vr),
    .root_o  (len),
    .side_o  (sr)
  );

  // scale factor setup
  logic           vf_q;
  jdz_pkg::side_t sf_d, sf_q;
  logic [23:0]    n1, dscale;
  logic [15:0]    sd;
  logic [39:0]    fnum_q;
  logic [23:0]    fden_q;

  assign n1     = len - {1'b0, sdz_q, 8'd0};
  assign sd     = sfs_q - {1'b0, sdz_q};
  assign dscale = {sd, 8'd0};

  always_comb begin
    sf_d        = sr;
    sf_d.len    = len;
    sf_d.f_full = (sfs_q <= {1'b0, sdz_q}) || (n1 >= dscale);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vf_q <= 1'b0;
    end else begin
      vf_q <= vr;
    end
  end

  always_ff @(posedge clk_i) begin
    sf_q   <= sf_d;
    fnum_q <= {1'b0, n1, 15'd0};
    fden_q <= dscale;
  end

  logic           vq;
  logic [15:0]    fq_raw;
  jdz_pkg::side_t sq;

  jdz_div u_fdiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (vf_q),
    .num_i   (fnum_q),
    .den_i   (fden_q),
    .side_i  (sf_q),
    .valid_o (vq),
    .quot_o  (fq_raw),
    .side_o  (sq)
  );

  // component products
  logic           vm_q;
  jdz_pkg::side_t sm_q;
  logic [15:0]    fq;
  logic [31:0]    px_q, py_q;

  assign fq = sq.f_full ? jdz_pkg::FullMag : fq_raw;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vm_q <= 1'b0;
    end else begin
      vm_q <= vq;
    end
  end

  always_ff @(posedge clk_i) begin
    sm_q <= sq;
    px_q <= sq.ax * fq;
    py_q <= sq.ay * fq;
  end

  // rounding offset
  logic           vn_q;
  jdz_pkg::side_t sn_q;
  logic [39:0]    nx_q, ny_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vn_q <= 1'b0;
    end else begin
      vn_q <= vm_q;
    end
  end

  always_ff @(posedge clk_i) begin
    sn_q <= sm_q;
    nx_q <= {px_q, 8'd0} + {17'd0, sm_q.len[23:1]};
    ny_q <= {py_q, 8'd0} + {17'd0, sm_q.len[23:1]};
  end

  logic           vx;
  logic [15:0]    qx, qy;
  jdz_pkg::side_t sx;

  jdz_div u_xdiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (vn_q),
    .num_i   (nx_q),
    .den_i   (sn_q.len),
    .side_i  (sn_q),
    .valid_o (vx),
    .quot_o  (qx),
    .side_o  (sx)
  );

  jdz_div u_ydiv (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (vn_q),
    .num_i   (ny_q),
    .den_i   (sn_q.len),
    .side_i  (sn_q),
    .valid_o (),
    .quot_o  (qy),
    .side_o  ()
  );

  // output stage
  logic        done_q, stick_q;
  logic [15:0] ox_d, oy_d, ox_q, oy_q;

  always_comb begin
    ox_d = '0;
    oy_d = '0;
    if (!sx.stick) begin
      if (!sx.t_zero) begin
        ox_d = jdz_pkg::sat_out(sx.t_full ? jdz_pkg::FullMag : sx.trig_q, sx.neg_x);
      end
    end else if (!sx.s_zero && (sx.len != '0)) begin
      ox_d = jdz_pkg::sat_out(qx, sx.neg_x);
      oy_d = jdz_pkg::sat_out(qy, sx.neg_y);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= vx;
    end
  end

  always_ff @(posedge clk_i) begin
    ox_q    <= ox_d;
    oy_q    <= oy_d;
    stick_q <= sx.stick;
  end

  assign done_o  = done_q;
  assign out_x_o = ox_q;
  assign out_y_o = oy_q;

  a_latency : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##(jdz_pkg::PipeDepth) done_o)
    else $error("request did not produce a result on time");

  a_no_spurious : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, jdz_pkg::PipeDepth))
    else $error("result without a matching request");

  a_trig_y_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !stick_q) |-> (out_y_o == 16'd0))
    else $error("trigger result with nonzero y");

endmodule

`default_nettype wire

### src/jdz_div.sv
// jdz_div: pipelined restoring divider, one quotient bit per stage, 16 stages
// quotient must fit 16 bits; depends on jdz_pkg
`default_nettype none

module jdz_div (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           valid_i,
  input  wire logic [39:0]    num_i,
  input  wire logic [23:0]    den_i,
  input  wire jdz_pkg::side_t side_i,
  output logic                valid_o,
  output logic [15:0]         quot_o,
  output jdz_pkg::side_t      side_o
);

  localparam int N = jdz_pkg::DivSteps;

  logic           vld_q [N];
  logic [39:0]    rem_q [N];
  logic [23:0]    den_q [N];
  logic [15:0]    quo_q [N];
  jdz_pkg::side_t sd_q  [N];

  for (genvar k = 0; k < N; k++) begin : g_st
    logic           v_in;
    logic [39:0]    rem_in;
    logic [23:0]    den_in;
    logic [15:0]    quo_in;
    jdz_pkg::side_t sd_in;
    logic [40:0]    trial;

    if (k == 0) begin : g_first
      assign v_in   = valid_i;
      assign rem_in = num_i;
      assign den_in = den_i;
      assign quo_in = '0;
      assign sd_in  = side_i;
    end else begin : g_next
      assign v_in   = vld_q[k-1];
      assign rem_in = rem_q[k-1];
      assign den_in = den_q[k-1];
      assign quo_in = quo_q[k-1];
      assign sd_in  = sd_q[k-1];
    end

    assign trial = {1'b0, rem_in} - ({17'd0, den_in} << (N - 1 - k));

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[k] <= trial[40] ? rem_in : trial[39:0];
      den_q[k] <= den_in;
      quo_q[k] <= {quo_in[14:0], ~trial[40]};
      sd_q[k]  <= sd_in;
    end
  end

  assign valid_o = vld_q[N-1];
  assign quot_o  = quo_q[N-1];
  assign side_o  = sd_q[N-1];

endmodule

`default_nettype wire

### src/jdz_sqrt.sv
// jdz_sqrt: pipelined integer square root of a 48 bit radicand, one root bit per stage
// depends on jdz_pkg
`default_nettype none

module jdz_sqrt (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           valid_i,
  input  wire logic [47:0]    rad_i,
  input  wire jdz_pkg::side_t side_i,
  output logic                valid_o,
  output logic [23:0]         root_o,
  output jdz_pkg::side_t      side_o
);

  localparam int N = jdz_pkg::SqrtSteps;

  logic           vld_q  [N];
  logic [47:0]    rem_q  [N];
  logic [23:0]    root_q [N];
  jdz_pkg::side_t sd_q   [N];

  for (genvar k = 0; k < N; k++) begin : g_st
    localparam int I = N - 1 - k;
    logic           v_in;
    logic [47:0]    rem_in;
    logic [23:0]    root_in;
    jdz_pkg::side_t sd_in;
    logic [48:0]    trial;

    if (k == 0) begin : g_first
      assign v_in    = valid_i;
      assign rem_in  = rad_i;
      assign root_in = '0;
      assign sd_in   = side_i;
    end else begin : g_next
      assign v_in    = vld_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign sd_in   = sd_q[k-1];
    end

    // (r + 2^i)^2 - r^2 = r*2^(i+1) + 2^(2i)
    assign trial = {1'b0, rem_in} - (({25'd0, root_in} << (I + 1)) + (49'd1 << (2 * I)));

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[k]  <= trial[48] ? rem_in : trial[47:0];
      root_q[k] <= trial[48] ? root_in : (root_in | (24'd1 << I));
      sd_q[k]   <= sd_in;
    end
  end

  assign valid_o = vld_q[N-1];
  assign root_o  = root_q[N-1];
  assign side_o  = sd_q[N-1];

endmodule

`default_nettype wire

### tb/joystick_dead_zone_filter_test.sv
// joystick_dead_zone_filter_test: self-checking testbench for the dead zone filter
// predicts trigger and stick results in fixed point and compares each strobed result
// depends on jdz_pkg and joystick_dead_zone_filter
`default_nettype none

module joystick_dead_zone_filter_test;

  typedef enum logic {KindTrig = 1'b0, KindStick = 1'b1} kind_e;

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
  } filt_res_t;

  localparam int Latency = 79;
  localparam longint CycleLimit = 400000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        kind_i = 1'b0;
  logic [15:0] axis_x_i = '0;
  logic [15:0] axis_y_i = '0;
  logic        done_o;
  logic [15:0] out_x_o;
  logic [15:0] out_y_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  logic [14:0] trig_dead;
  logic [14:0] trig_full;
  logic [14:0] stick_dead;
  logic [15:0] stick_full;

  filt_res_t   expected_q[$];
  int          mismatches = 0;
  int          results_seen = 0;
  int          requests_sent = 0;
  longint      cycles = 0;

  joystick_dead_zone_filter dut (
    .clk_i, .rst_ni, .start, .busy, .kind_i, .axis_x_i, .axis_y_i,
    .done_o, .out_x_o, .out_y_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic logic [63:0] root64(input logic [63:0] n);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [15:0] clamp_sign(input logic [63:0] mag, input logic neg);
    if (neg) begin
      if (mag > 32768) mag = 32768;
      return 16'(-mag);
    end
    if (mag > 32767) mag = 32767;
    return mag[15:0];
  endfunction

  function automatic filt_res_t dead_zone_result(input kind_e kind, input logic [15:0] xr,
                                                 input logic [15:0] yr);
    filt_res_t   r;
    logic [63:0] ax, ay, dz, fs, d, q, s, len, fq, mx, my;
    ax = xr[15] ? 64'(-$signed({48'hffffffffffff, xr})) : 64'(xr);
    ay = yr[15] ? 64'(-$signed({48'hffffffffffff, yr})) : 64'(yr);
    r = '0;
    if (kind == KindTrig) begin
      dz = trig_dead;
      fs = trig_full;
      if (ax <= dz) return r;
      if (fs <= dz) q = 32768;
      else begin
        d = fs - dz;
        q = ((ax - dz) * 32768 + d / 2) / d;
      end
      r.x = clamp_sign(q, xr[15] || xr == 0);
      return r;
    end
    dz = stick_dead;
    fs = stick_full;
    s = ax * ax + ay * ay;
    if (s < dz * dz) return r;
    len = root64(s << 16);
    if (len == 0) return r;
    if (fs <= dz) fq = 32768;
    else begin
      d = (fs - dz) * 256;
      fq = ((len - dz * 256) * 32768) / d;
      if (fq > 32768) fq = 32768;
    end
    mx = (ax * fq * 256 + len / 2) / len;
    my = (ay * fq * 256 + len / 2) / len;
    r.x = clamp_sign(mx, xr[15]);
    r.y = clamp_sign(my, yr[15]);
    return r;
  endfunction

  always @(posedge clk_i) begin
    filt_res_t e;
    if (rst_ni && done_o) begin
      results_seen++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result x=%h y=%h", out_x_o, out_y_o);
      end else begin
        e = expected_q.pop_front();
        if (e.x !== out_x_o || e.y !== out_y_o) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected x=%h y=%h, got x=%h y=%h", e.x, e.y, out_x_o,
                     out_y_o);
        end
      end
    end
  end

  task automatic send_request(input kind_e kind, input logic [15:0] x, input logic [15:0] y,
                              input bit gaps);
    int gap;
    gap = gaps ? $urandom_range(0, 3) : 0;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start <= 1'b1;
    kind_i <= kind;
    axis_x_i <= x;
    axis_y_i <= y;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    expected_q.push_back(dead_zone_result(kind, x, y));
    requests_sent++;
    @(negedge clk_i);
  endtask

  task automatic drain;
    start <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (Latency + 5) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    case (idx)
      jdz_pkg::RegTrigDead:  trig_dead = val[14:0];
      jdz_pkg::RegTrigFull:  trig_full = val[14:0];
      jdz_pkg::RegStickDead: stick_dead = val[14:0];
      jdz_pkg::RegStickFull: stick_full = val[15:0];
      default: ;
    endcase
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic set_config(input logic [14:0] td, input logic [14:0] tf, input logic [14:0] sd,
                            input logic [15:0] sf);
    drain();
    write_reg(jdz_pkg::RegTrigDead, 32'(td));
    write_reg(jdz_pkg::RegTrigFull, 32'(tf));
    write_reg(jdz_pkg::RegStickDead, 32'(sd));
    write_reg(jdz_pkg::RegStickFull, 32'(sf));
  endtask

  task automatic test_directed;
    send_request(KindTrig, 16'h0000, 16'h0000, 0);
    send_request(KindTrig, 16'd250, 16'hffff, 0);
    send_request(KindTrig, 16'd251, 16'h1234, 0);
    send_request(KindTrig, 16'h7fff, 16'h0000, 0);
    send_request(KindTrig, 16'h8000, 16'h0000, 0);
    send_request(KindTrig, -16'sd250, 16'h0000, 0);
    send_request(KindTrig, -16'sd15000, 16'h0000, 0);
    send_request(KindStick, 16'h0000, 16'h0000, 0);
    send_request(KindStick, 16'd7999, 16'h0000, 0);
    send_request(KindStick, 16'd8000, 16'h0000, 0);
    send_request(KindStick, 16'h7fff, 16'h7fff, 0);
    send_request(KindStick, 16'h8000, 16'h8000, 0);
    send_request(KindStick, 16'h8000, 16'h7fff, 0);
    send_request(KindStick, -16'sd12000, 16'd9000, 0);
    send_request(KindStick, 16'd5657, -16'sd5657, 0);
    send_request(KindStick, 16'd20000, 16'd1, 0);
  endtask

  task automatic test_special_config;
    set_config(15'd0, 15'd1, 15'd0, 16'd1);
    send_request(KindStick, 16'h0000, 16'h0000, 0);
    send_request(KindTrig, 16'h0000, 16'h0000, 0);
    send_request(KindTrig, 16'h0001, 16'h0000, 0);
    send_request(KindStick, 16'h0001, 16'hffff, 0);
    set_config(15'd32767, 15'd100, 15'd32767, 16'd100);
    send_request(KindTrig, 16'h8000, 16'h0000, 0);
    send_request(KindTrig, 16'h7fff, 16'h0000, 0);
    send_request(KindStick, 16'h8000, 16'h8000, 0);
    send_request(KindStick, 16'd32766, 16'h0000, 0);
    set_config(15'd0, 15'd32767, 15'd0, 16'd46341);
    send_request(KindTrig, 16'h8000, 16'h0000, 0);
    send_request(KindStick, 16'h8000, 16'h8000, 0);
    send_request(KindStick, 16'h0003, 16'h0004, 0);
    set_config(15'd32767, 15'd32767, 15'd32767, 16'd65535);
    send_request(KindStick, 16'h8000, 16'h8000, 0);
    send_request(KindTrig, 16'h8000, 16'h0000, 0);
  endtask

  task automatic random_phase(input int n);
    kind_e       k;
    logic [15:0] x, y;
    for (int i = 0; i < n; i++) begin
      k = kind_e'($urandom_range(0, 1));
      case ($urandom_range(0, 3))
        0: begin x = 16'($urandom); y = 16'($urandom); end
        1: begin x = 16'($urandom_range(0, 2000)) - 16'd1000;
                 y = 16'($urandom_range(0, 2000)) - 16'd1000; end
        2: begin x = $urandom_range(0, 1) ? 16'h8000 : 16'h7fff; y = 16'($urandom); end
        default: begin x = 16'($signed(16'($urandom_range(0, 24000))) - 16'sd12000);
                       y = 16'($signed(16'($urandom_range(0, 24000))) - 16'sd12000); end
      endcase
      send_request(k, x, y, $urandom_range(0, 3) != 0);
    end
  endtask

  task automatic test_random;
    set_config(15'd250, 15'd30000, 15'd8000, 16'd30000);
    random_phase(500);
    drain();
    random_phase(100);
    set_config(15'($urandom_range(0, 8000)), 15'($urandom_range(9000, 32767)),
               15'($urandom_range(0, 12000)), 16'($urandom_range(13000, 46341)));
    random_phase(500);
    set_config(15'($urandom), 15'($urandom), 15'($urandom), 16'($urandom));
    random_phase(300);
    set_config(15'($urandom_range(0, 100)), 15'($urandom_range(0, 200)),
               15'($urandom_range(0, 100)), 16'($urandom_range(0, 200)));
    random_phase(400);
  endtask

  initial begin
    trig_dead = jdz_pkg::TrigDeadRst;
    trig_full = jdz_pkg::TrigFullRst;
    stick_dead = jdz_pkg::StickDeadRst;
    stick_full = jdz_pkg::StickFullRst;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    test_special_config();
    test_random();
    drain();
    $display("sent %0d requests over several register settings, checked %0d results",
             requests_sent, results_seen);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, expected_q.size());
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

### filelist.f
src/jdz_pkg.sv
src/jdz_div.sv
src/jdz_sqrt.sv
src/joystick_dead_zone_filter.sv
tb/joystick_dead_zone_filter_test.sv
